### hw/rtl/dct_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dct_pkg
// Shared constants and types for the dirty cluster tracker.
// ============================================================================
package dct_pkg;
    localparam int MAX_CLUSTERS = 65536;
    localparam int IDX_W   = $clog2(MAX_CLUSTERS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int ROW_W   = 32;
    localparam int ROW_AW  = (IDX_W > 5) ? IDX_W - 5 : 1;
    localparam int ROWS    = MAX_CLUSTERS / ROW_W;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_NEXT  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_INACTIVE = 2'd2;
    localparam logic [1:0] ST_ACTIVE   = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [IDX_W-1:0] cluster;
    } result_t;
endpackage

### hw/rtl/dct_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// dct_ram
// Generic single-port RAM with registered read.
// ============================================================================
module dct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hw/rtl/dct_div.sv
`timescale 1ns / 1ps
// ============================================================================
// dct_div
// Radix-2 restoring divider, one quotient bit per cycle (42 / 25 bits).
// ============================================================================
module dct_div
    import dct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [41:0] dividend,
    input  logic [24:0] divisor,
    output logic        done,
    output logic [41:0] quotient
);
    logic [41:0] q_reg, q_next;
    logic [25:0] r_reg, r_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [25:0] trial;
    logic [26:0] diff;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        trial = {r_reg[24:0], q_reg[41]};
        diff  = {1'b0, trial} - {2'b0, divisor};
        if (start) begin
            q_next = dividend;
            r_next = '0;
            n_next = 6'd42;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[26]) begin
                r_next = diff[25:0];
                q_next = {q_reg[40:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[40:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // final quotient from the last shift step, valid while done is high
    assign done = busy_reg && (n_reg == 6'd1);
    assign quotient = {q_reg[40:0], ~diff[26]};
endmodule

### hw/rtl/dirty_cluster_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// dirty_cluster_tracker
// Changed-block tracking: one dirty bit per cluster, mark, clear, scan.
// ============================================================================
// One word is taken at a time; s_tready is low while it is processed. The
// bitmap lives in a RAM of 32-bit rows, one row per step through a
// read-modify-write sequencer. A write word runs two divisions on the
// shared divider (first and last cluster) and then a read and a write
// state per row touched. Clear reads and rewrites a single row. Get next
// reads and checks one row at a time, up to MAX_CLUSTERS/32 + 1 rows.
// Start clears the map by a sweep over all MAX_CLUSTERS/32 rows (2048 at
// the default). After reset the same sweep runs once before the first word
// is accepted; configuration writes are taken throughout. The result waits
// in an output register; a new word is not taken until it is delivered.
module dirty_cluster_tracker
    import dct_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: opcode[2:0], sector[34:3], byte_count[66:35], cluster_index[82:67]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: status[1:0], found[2], found_cluster[18:3]
    output logic [23:0] m_tdata
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DIV1  = 4'd2;
    localparam logic [3:0] S_DIV2  = 4'd3;
    localparam logic [3:0] S_MRD   = 4'd4;
    localparam logic [3:0] S_MWR   = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_SWR   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [15:0] csz_reg;
    logic [16:0] ccnt_reg;
    logic        active_reg, active_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [2:0]  op_reg;
    logic [31:0] sec_reg, len_reg;
    logic [IDX_W-1:0] cidx_reg;
    logic [40:0] first_reg, first_next;
    logic [40:0] last_reg, last_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic        wrap_reg, wrap_next;
    result_t     res_reg, res_next;
    logic        mval_reg, mval_next;

    // effective count
    logic [CNT_W-1:0] n_eff;
    always_comb begin
        if (ccnt_reg == 17'd0) n_eff = CNT_W'(1);
        else if ({{(CNT_W > 17 ? CNT_W-17 : 0){1'b0}}, ccnt_reg} > CNT_W'(MAX_CLUSTERS))
            n_eff = CNT_W'(MAX_CLUSTERS);
        else n_eff = CNT_W'(ccnt_reg);
    end

    // divider; the end offset of a write needs 42 bits
    logic        div_start, div_done;
    logic [41:0] div_dvd, div_q;
    logic [24:0] div_dsr;
    assign div_dsr = {(csz_reg == 16'd0) ? 16'd1 : csz_reg, 9'd0};
    dct_div u_div (.aclk, .aresetn, .start(div_start), .dividend(div_dvd),
                   .divisor(div_dsr), .done(div_done), .quotient(div_q));

    // bitmap RAM
    logic              ram_we;
    logic [ROW_AW-1:0] ram_addr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    dct_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_map (
        .aclk, .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata));

    // row mask for marking [first, last] within the current row
    logic [ROW_W-1:0] mark_mask;
    logic [40:0] row_lo;
    always_comb begin
        row_lo = {{(41-ROW_AW-5){1'b0}}, row_reg, 5'd0};
        for (int b = 0; b < ROW_W; b++) begin
            mark_mask[b] = (row_lo + 41'(b) >= first_reg) && (row_lo + 41'(b) <= last_reg);
        end
    end

    // scan: candidate mask and lowest set bit within current row
    logic [ROW_W-1:0] scan_mask, hit_bits;
    logic [4:0]       hit_pos;
    logic             hit_any;
    logic [CNT_W-1:0] start_i;
    always_comb begin
        for (int b = 0; b < ROW_W; b++) begin
            logic [CNT_W-1:0] ix;
            ix = {row_reg, 5'd0} + CNT_W'(b);
            scan_mask[b] = (ix < n_eff) &&
                (wrap_reg ? (ix <= base_reg) : (ix > base_reg));
        end
        hit_bits = ram_rdata & scan_mask;
        hit_any = |hit_bits;
        hit_pos = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (hit_bits[b]) hit_pos = 5'(b);
        end
    end

    logic [IDX_W-1:0] prev_c;
    assign prev_c = ({1'b0, cursor_reg} >= n_eff) ? '0 : cursor_reg;
    assign start_i = {1'b0, prev_c};

    logic in_fire, out_fire;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign s_tready = (state_reg == S_IDLE) && !mval_reg;

    logic [CNT_W-1:0] last_row_ix;

    always_comb begin
        state_next = state_reg;
        active_next = active_reg;
        cursor_next = cursor_reg;
        first_next = first_reg;
        last_next = last_reg;
        row_next = row_reg;
        left_next = left_reg;
        base_next = base_reg;
        wrap_next = wrap_reg;
        res_next = res_reg;
        mval_next = mval_reg && !out_fire;
        div_start = 1'b0;
        div_dvd = '0;
        ram_we = 1'b0;
        ram_addr = row_reg;
        ram_wdata = '0;
        last_row_ix = n_eff - CNT_W'(1);
        unique case (state_reg)
            S_CLR: begin
                ram_we = 1'b1;
                row_next = row_reg + 1'b1;
                if (row_reg == ROW_AW'(ROWS - 1)) begin
                    row_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    res_next = '0;
                    state_next = S_OUT;
                    unique case (s_tdata[2:0])
                        OP_WRITE: begin
                            if (active_reg && s_tdata[66:35] != 32'd0) begin
                                div_start = 1'b1;
                                div_dvd = {1'b0, s_tdata[34:3], 9'd0};
                                state_next = S_DIV1;
                            end
                        end
                        OP_CLEAR: begin
                            if ({1'b0, s_tdata[82:67]} >= n_eff)
                                res_next.status = ST_INVALID;
                            else if (!active_reg) res_next.status = ST_INACTIVE;
                            else begin
                                row_next = s_tdata[82:72];
                                state_next = S_MRD;
                            end
                        end
                        OP_NEXT: begin
                            if (!active_reg) res_next.status = ST_INACTIVE;
                            else begin
                                base_next = start_i;
                                wrap_next = (start_i == last_row_ix);
                                row_next = (start_i == last_row_ix) ? '0 : start_i[IDX_W-1:5];
                                left_next = CNT_W'(ROWS + 1);
                                state_next = S_SRD;
                            end
                        end
                        OP_START: begin
                            if (active_reg) res_next.status = ST_ACTIVE;
                            else begin
                                active_next = 1'b1;
                                cursor_next = last_row_ix[IDX_W-1:0];
                                row_next = '0;
                                state_next = S_CLR;
                            end
                        end
                        OP_STOP: begin
                            if (!active_reg) res_next.status = ST_INACTIVE;
                            else active_next = 1'b0;
                        end
                        default: ;
                    endcase
                    mval_next = (state_next != S_CLR) ? (state_next == S_OUT) : 1'b0;
                    if (state_next == S_OUT) state_next = S_IDLE;
                    if (state_next == S_CLR) mval_next = 1'b1;
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    first_next = div_q[40:0];
                    div_start = 1'b1;
                    div_dvd = {1'b0, sec_reg, 9'd0} + {10'd0, len_reg} - 42'd1;
                    state_next = S_DIV2;
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    last_next = (div_q > 42'(last_row_ix)) ? 41'(last_row_ix) : div_q[40:0];
                    if (first_reg > last_next) begin
                        mval_next = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        row_next = first_reg[IDX_W-1:5];
                        state_next = S_MRD;
                    end
                end
            end
            S_MRD: state_next = S_MWR;
            S_MWR: begin
                ram_we = 1'b1;
                if (op_reg == OP_CLEAR) begin
                    ram_wdata = ram_rdata & ~(ROW_W'(1) << cidx_reg[4:0]);
                    mval_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    ram_wdata = ram_rdata | mark_mask;
                    if (row_lo + 41'd31 >= last_reg) begin
                        mval_next = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        row_next = row_reg + 1'b1;
                        state_next = S_MRD;
                    end
                end
            end
            S_SRD: state_next = S_SCHK;
            S_SCHK: begin
                if (hit_any) begin
                    cursor_next = {row_reg, hit_pos};
                    res_next.found = 1'b1;
                    res_next.cluster = 16'({row_reg, hit_pos});
                    state_next = S_SWR;
                end else if (left_reg == CNT_W'(1)) begin
                    mval_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    left_next = left_reg - 1'b1;
                    if ({row_reg, 5'd31} >= last_row_ix[IDX_W-1:0]) begin
                        row_next = '0;
                        wrap_next = 1'b1;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                    state_next = S_SRD;
                end
            end
            S_SWR: begin
                ram_we = 1'b1;
                ram_wdata = ram_rdata & ~(ROW_W'(1) << cursor_reg[4:0]);
                mval_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            active_reg <= 1'b0;
            cursor_reg <= '0;
            csz_reg <= 16'd8;
            ccnt_reg <= 17'd65536;
            mval_reg <= 1'b0;
            row_reg <= '0;
        end else begin
            state_reg <= state_next;
            active_reg <= active_next;
            cursor_reg <= cursor_next;
            mval_reg <= mval_next;
            row_reg <= row_next;
            if (psel && penable && pwrite) begin
                if (paddr[2] == 1'b0) csz_reg <= pwdata[15:0];
                else ccnt_reg <= pwdata[16:0];
            end
        end
        first_reg <= first_next;
        last_reg <= last_next;
        left_reg <= left_next;
        base_reg <= base_next;
        wrap_reg <= wrap_next;
        res_reg <= res_next;
        if (in_fire) begin
            op_reg <= s_tdata[2:0];
            sec_reg <= s_tdata[34:3];
            len_reg <= s_tdata[66:35];
            cidx_reg <= s_tdata[82:67];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, csz_reg} : {15'd0, ccnt_reg};
    assign m_tvalid = mval_reg && (state_reg == S_IDLE);
    assign m_tdata = {5'd0, res_reg.cluster, res_reg.found, res_reg.status};

    ap_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    ap_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.found) |-> (res_reg.status == ST_OK)) else $error("found bad");
endmodule
